>>> design/psba_pkg.sv
package psba_pkg;

    localparam int SLOT_COUNT = 64;
    localparam int PAGE_SHIFT = 12;
    localparam int SLOT_W     = 6;
    localparam int ADDR_W     = 64;

    typedef logic [ADDR_W-1:0] addr_t;
    typedef logic [SLOT_W-1:0] slot_t;

    typedef enum logic [1:0] {
        CMD_ATTACH      = 2'd0,
        CMD_ATTACH_COPY = 2'd1,
        CMD_DETACH      = 2'd2,
        CMD_INVALID     = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        ST_OK          = 2'd0,
        ST_WOULD_BLOCK = 2'd1,
        ST_MUST_WAIT   = 2'd2,
        ST_BAD_DETACH  = 2'd3
    } status_t;

    localparam addr_t NO_TARGET = '1;

    // Bitmap lanes that belong to real slots.
    localparam logic [63:0] SLOT_MASK =
        (SLOT_COUNT == 64) ? 64'hFFFF_FFFF_FFFF_FFFF : ((64'd1 << SLOT_COUNT) - 64'd1);

endpackage

>>> design/page_slot_bitmap_allocator_unit.sv
// Transactions pass the input stage, then the result stage. Throughput: one
// per cycle while m_ready does not stall the output, limited by the combinational
// find-first-free over the used bitmap and one target table port per stage.
// Reset (aresetn low, synchronous): clears the used bitmap, pending waiters,
// the region base and both valid stages. The target table is not cleared; an
// entry is read only for a slot whose used bit is set, so it was written.
module page_slot_bitmap_allocator_unit (
    input  logic                   aclk,
    input  logic                   aresetn,

    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  psba_pkg::addr_t        cfg_data,

    input  logic                   s_valid,
    output logic                   s_ready,
    input  logic [1:0]             s_command,
    input  psba_pkg::addr_t        s_phys_addr,
    input  psba_pkg::addr_t        s_release_addr,
    input  logic                   s_has_restart,

    output logic                   m_valid,
    input  logic                   m_ready,
    output logic [1:0]             m_status,
    output psba_pkg::addr_t        m_mapped_addr,
    output psba_pkg::slot_t        m_slot,
    output logic                   m_copy_in,
    output logic                   m_copy_back,
    output psba_pkg::addr_t        m_copy_phys,
    output logic                   m_wake_waiters
);

    // configuration
    psba_pkg::addr_t region_base_reg;

    // architectural state
    logic [63:0]     used_map_reg;
    logic            waiters_pending_reg;
    psba_pkg::addr_t target_mem [psba_pkg::SLOT_COUNT];

    // input stage
    logic            p_valid_reg;
    logic [1:0]      p_cmd_reg;
    psba_pkg::addr_t p_phys_reg;
    logic            p_restart_reg;
    psba_pkg::slot_t p_idx_reg;
    logic            p_in_range_reg;
    psba_pkg::addr_t target_rd_reg;

    // result stage
    logic            m_valid_reg;
    logic [1:0]      m_status_reg;
    psba_pkg::addr_t m_mapped_addr_reg;
    psba_pkg::slot_t m_slot_reg;
    logic            m_copy_in_reg;
    logic            m_copy_back_reg;
    psba_pkg::addr_t m_copy_phys_reg;
    logic            m_wake_waiters_reg;

    logic            s_fire;
    logic            p_fire;
    psba_pkg::addr_t rel_offset;
    psba_pkg::addr_t rel_index;
    psba_pkg::slot_t rd_idx;
    logic            rd_in_range;

    logic            any_free;
    psba_pkg::slot_t free_idx;
    logic            is_attach;
    logic            is_detach_ok;
    logic            tgt_wen;

    logic [1:0]      m_status_next;
    psba_pkg::addr_t m_mapped_addr_next;
    psba_pkg::slot_t m_slot_next;
    logic            m_copy_in_next;
    logic            m_copy_back_next;
    psba_pkg::addr_t m_copy_phys_next;
    logic            m_wake_waiters_next;
    logic [63:0]     used_map_next;
    logic            waiters_pending_next;

    assign cfg_ready = 1'b1;

    assign p_fire  = p_valid_reg && (!m_valid_reg || m_ready);
    assign s_ready = !p_valid_reg || p_fire;
    assign s_fire  = s_valid && s_ready;

    // map the release address back to a slot on the way in
    assign rel_offset  = s_release_addr - region_base_reg;
    assign rel_index   = rel_offset >> psba_pkg::PAGE_SHIFT;
    assign rd_idx      = rel_index[psba_pkg::SLOT_W-1:0];
    assign rd_in_range = rel_index < psba_pkg::ADDR_W'(psba_pkg::SLOT_COUNT);

    always_comb begin
        any_free = 1'b0;
        free_idx = '0;
        for (int i = psba_pkg::SLOT_COUNT - 1; i >= 0; i--) begin
            if (!used_map_reg[i]) begin
                any_free = 1'b1;
                free_idx = psba_pkg::SLOT_W'(i);
            end
        end
    end

    assign is_attach    = (p_cmd_reg == psba_pkg::CMD_ATTACH) ||
                          (p_cmd_reg == psba_pkg::CMD_ATTACH_COPY);
    assign is_detach_ok = (p_cmd_reg == psba_pkg::CMD_DETACH) && p_in_range_reg &&
                          used_map_reg[p_idx_reg];
    assign tgt_wen      = p_fire && is_attach && any_free;

    always_comb begin
        m_status_next        = psba_pkg::ST_BAD_DETACH;
        m_mapped_addr_next   = '0;
        m_slot_next          = '0;
        m_copy_in_next       = 1'b0;
        m_copy_back_next     = 1'b0;
        m_copy_phys_next     = '0;
        m_wake_waiters_next  = 1'b0;
        used_map_next        = used_map_reg;
        waiters_pending_next = waiters_pending_reg;
        if (is_attach) begin
            if (any_free) begin
                m_status_next      = psba_pkg::ST_OK;
                m_mapped_addr_next = region_base_reg +
                    (psba_pkg::ADDR_W'(free_idx) << psba_pkg::PAGE_SHIFT);
                m_slot_next        = free_idx;
                m_copy_in_next     = (p_cmd_reg == psba_pkg::CMD_ATTACH_COPY);
                used_map_next[free_idx] = 1'b1;
            end else begin
                m_status_next        = p_restart_reg ? psba_pkg::ST_WOULD_BLOCK
                                                     : psba_pkg::ST_MUST_WAIT;
                waiters_pending_next = 1'b1;
            end
        end else if (is_detach_ok) begin
            m_status_next       = psba_pkg::ST_OK;
            m_slot_next         = p_idx_reg;
            if (target_rd_reg != psba_pkg::NO_TARGET) begin
                m_copy_back_next = 1'b1;
                m_copy_phys_next = target_rd_reg;
            end
            m_wake_waiters_next  = waiters_pending_reg;
            waiters_pending_next = 1'b0;
            used_map_next[p_idx_reg] = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            region_base_reg     <= '0;
            used_map_reg        <= '0;
            waiters_pending_reg <= 1'b0;
            p_valid_reg         <= 1'b0;
            m_valid_reg         <= 1'b0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                region_base_reg <= cfg_data;
            end
            if (s_fire) begin
                p_valid_reg <= 1'b1;
            end else if (p_fire) begin
                p_valid_reg <= 1'b0;
            end
            if (p_fire) begin
                m_valid_reg         <= 1'b1;
                used_map_reg        <= used_map_next & psba_pkg::SLOT_MASK;
                waiters_pending_reg <= waiters_pending_next;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // input stage payload
    always_ff @(posedge aclk) begin
        if (s_fire) begin
            p_cmd_reg      <= s_command;
            p_phys_reg     <= s_phys_addr;
            p_restart_reg  <= s_has_restart;
            p_idx_reg      <= rd_idx;
            p_in_range_reg <= rd_in_range;
        end
    end

    // target table: one write port, one registered read port
    always_ff @(posedge aclk) begin
        if (tgt_wen) begin
            target_mem[free_idx] <= p_phys_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            // forward an attach that writes the same slot this cycle
            if (tgt_wen && (free_idx == rd_idx)) begin
                target_rd_reg <= p_phys_reg;
            end else begin
                target_rd_reg <= target_mem[rd_idx];
            end
        end
    end

    // result stage payload
    always_ff @(posedge aclk) begin
        if (p_fire) begin
            m_status_reg       <= m_status_next;
            m_mapped_addr_reg  <= m_mapped_addr_next;
            m_slot_reg         <= m_slot_next;
            m_copy_in_reg      <= m_copy_in_next;
            m_copy_back_reg    <= m_copy_back_next;
            m_copy_phys_reg    <= m_copy_phys_next;
            m_wake_waiters_reg <= m_wake_waiters_next;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_status       = m_status_reg;
    assign m_mapped_addr  = m_mapped_addr_reg;
    assign m_slot         = m_slot_reg;
    assign m_copy_in      = m_copy_in_reg;
    assign m_copy_back    = m_copy_back_reg;
    assign m_copy_phys    = m_copy_phys_reg;
    assign m_wake_waiters = m_wake_waiters_reg;

    a_attach_marks_used : assert property (@(posedge aclk) disable iff (!aresetn)
        tgt_wen |=> used_map_reg[$past(free_idx)])
        else $error("attached slot not marked used");

    a_detach_frees_slot : assert property (@(posedge aclk) disable iff (!aresetn)
        (p_fire && is_detach_ok) |=> !used_map_reg[$past(p_idx_reg)])
        else $error("detached slot still marked used");

    a_wake_clears_pending : assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_wake_waiters_reg) |-> !waiters_pending_reg)
        else $error("waiters still pending after wake");

    a_stall_only_when_full : assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> (p_valid_reg && m_valid_reg && !m_ready))
        else $error("input stalled while pipeline can advance");

endmodule

>>> tb/page_slot_bitmap_allocator_unit_test.sv
module page_slot_bitmap_allocator_unit_test;
    timeunit 1ns;
    timeprecision 1ps;

    import psba_pkg::*;

    localparam int  CLK_HALF     = 6;
    localparam int  DRAIN_CYCLES = 8;
    localparam int  CYCLE_LIMIT  = 400000;
    localparam addr_t PAGE_OFFS  = addr_t'((64'd1 << PAGE_SHIFT) - 64'd1);
    localparam addr_t TOP_BASE   = ~PAGE_OFFS;

    typedef struct packed {
        cmd_t  command;
        addr_t phys_addr;
        addr_t release_addr;
        logic  has_restart;
    } slot_request_t;

    typedef struct packed {
        status_t status;
        addr_t   mapped_addr;
        slot_t   slot;
        logic    copy_in;
        logic    copy_back;
        addr_t   copy_phys;
        logic    wake_waiters;
    } slot_outcome_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;

    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    addr_t       cfg_data = '0;

    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [1:0]  s_command = '0;
    addr_t       s_phys_addr = '0;
    addr_t       s_release_addr = '0;
    logic        s_has_restart = 1'b0;

    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [1:0]  m_status;
    addr_t       m_mapped_addr;
    slot_t       m_slot;
    logic        m_copy_in;
    logic        m_copy_back;
    addr_t       m_copy_phys;
    logic        m_wake_waiters;

    // Shadow of the allocator state
    addr_t       window_base;
    logic [63:0] used_bits;
    addr_t       slot_target [SLOT_COUNT];
    logic        waiters_flag;

    slot_outcome_t outcome_queue [$];

    bit          quiet_mode = 1'b0;
    int          stall_left = 0;
    int          cycle_count = 0;
    int          error_count = 0;
    int          requests_sent = 0;
    int          outcomes_seen = 0;
    int          full_hits = 0;
    int          copy_backs = 0;
    int          wakes = 0;
    int          bad_detaches = 0;

    page_slot_bitmap_allocator_unit u_dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_data       (cfg_data),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_command      (s_command),
        .s_phys_addr    (s_phys_addr),
        .s_release_addr (s_release_addr),
        .s_has_restart  (s_has_restart),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_status       (m_status),
        .m_mapped_addr  (m_mapped_addr),
        .m_slot         (m_slot),
        .m_copy_in      (m_copy_in),
        .m_copy_back    (m_copy_back),
        .m_copy_phys    (m_copy_phys),
        .m_wake_waiters (m_wake_waiters)
    );

    initial begin
        forever #(CLK_HALF) aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, outcome_queue.size());
            $display("*** FAILED ***");
            $finish;
        end
    end

    // Result channel backpressure: mostly ready, short and occasional long stalls
    always @(posedge aclk) begin
        int pick;
        pick = $urandom_range(99);
        if (quiet_mode) begin
            stall_left <= 0;
            m_ready <= 1'b1;
        end else if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            m_ready <= 1'b0;
        end else if (pick < 25) begin
            m_ready <= 1'b0;
            stall_left <= (pick < 3) ? $urandom_range(30, 8) : $urandom_range(2, 0);
        end else begin
            m_ready <= 1'b1;
        end
    end

    always @(posedge aclk) begin : result_check
        slot_outcome_t got;
        slot_outcome_t want;
        if (aresetn && m_valid && m_ready) begin
            got.status       = status_t'(m_status);
            got.mapped_addr  = m_mapped_addr;
            got.slot         = m_slot;
            got.copy_in      = m_copy_in;
            got.copy_back    = m_copy_back;
            got.copy_phys    = m_copy_phys;
            got.wake_waiters = m_wake_waiters;
            outcomes_seen++;
            if (outcome_queue.size() == 0) begin
                error_count++;
                if (error_count <= 10)
                    $display("unexpected result transaction at cycle %0d", cycle_count);
            end else begin
                want = outcome_queue.pop_front();
                if (got !== want) begin
                    error_count++;
                    if (error_count <= 10) begin
                        $display("mismatch at cycle %0d", cycle_count);
                        $display("  status   exp %s act %s", want.status.name(),
                                 got.status.name());
                        $display("  mapped   exp %h act %h", want.mapped_addr,
                                 got.mapped_addr);
                        $display("  slot     exp %0d act %0d", want.slot, got.slot);
                        $display("  copy_in  exp %b act %b", want.copy_in, got.copy_in);
                        $display("  copyback exp %b act %b", want.copy_back,
                                 got.copy_back);
                        $display("  phys     exp %h act %h", want.copy_phys,
                                 got.copy_phys);
                        $display("  wake     exp %b act %b", want.wake_waiters,
                                 got.wake_waiters);
                    end
                end
            end
        end
    end

    function automatic addr_t rand_addr();
        return {$urandom, $urandom};
    endfunction

    function automatic int pick_gap();
        int pick;
        pick = $urandom_range(99);
        if (quiet_mode || pick < 60)
            return 0;
        if (pick < 92)
            return $urandom_range(3, 1);
        return $urandom_range(30, 8);
    endfunction

    // Lowest free slot wins; a detach decodes its page within the window
    function automatic slot_outcome_t predict_slot_outcome(input slot_request_t req);
        slot_outcome_t res;
        int            free_slot;
        addr_t         page_idx;
        res = '0;
        free_slot = -1;
        case (req.command)
            CMD_ATTACH, CMD_ATTACH_COPY: begin
                for (int s = SLOT_COUNT - 1; s >= 0; s--)
                    if (!used_bits[s])
                        free_slot = s;
                if (free_slot < 0) begin
                    waiters_flag = 1'b1;
                    res.status = req.has_restart ? ST_WOULD_BLOCK : ST_MUST_WAIT;
                    full_hits++;
                end else begin
                    used_bits[free_slot] = 1'b1;
                    slot_target[free_slot] = req.phys_addr;
                    res.status = ST_OK;
                    res.mapped_addr = window_base + (addr_t'(free_slot) << PAGE_SHIFT);
                    res.slot = slot_t'(free_slot);
                    res.copy_in = (req.command == CMD_ATTACH_COPY);
                end
            end
            CMD_DETACH: begin
                page_idx = (req.release_addr - window_base) >> PAGE_SHIFT;
                if (page_idx < SLOT_COUNT && used_bits[page_idx[SLOT_W-1:0]]) begin
                    res.status = ST_OK;
                    res.slot = page_idx[SLOT_W-1:0];
                    if (slot_target[page_idx[SLOT_W-1:0]] != NO_TARGET) begin
                        res.copy_back = 1'b1;
                        res.copy_phys = slot_target[page_idx[SLOT_W-1:0]];
                        copy_backs++;
                    end
                    slot_target[page_idx[SLOT_W-1:0]] = NO_TARGET;
                    used_bits[page_idx[SLOT_W-1:0]] = 1'b0;
                    res.wake_waiters = waiters_flag;
                    if (waiters_flag)
                        wakes++;
                    waiters_flag = 1'b0;
                end else begin
                    res.status = ST_BAD_DETACH;
                    bad_detaches++;
                end
            end
            default: begin
                res.status = ST_BAD_DETACH;
                bad_detaches++;
            end
        endcase
        return res;
    endfunction

    task automatic send_request(input slot_request_t req, input int gap);
        s_valid        <= 1'b1;
        s_command      <= req.command;
        s_phys_addr    <= req.phys_addr;
        s_release_addr <= req.release_addr;
        s_has_restart  <= req.has_restart;
        forever begin
            @(posedge aclk);
            if (s_ready)
                break;
        end
        outcome_queue.push_back(predict_slot_outcome(req));
        requests_sent++;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    // Hold the sender until every outstanding transaction has returned
    task automatic wait_for_results();
        s_valid <= 1'b0;
        while (outcome_queue.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic write_window_base(input addr_t value);
        wait_for_results();
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        forever begin
            @(posedge aclk);
            if (cfg_ready)
                break;
        end
        cfg_valid <= 1'b0;
        window_base = value;
    endtask

    function automatic slot_request_t attach_request(input addr_t phys);
        slot_request_t req;
        req.command      = $urandom_range(1) ? CMD_ATTACH_COPY : CMD_ATTACH;
        req.phys_addr    = phys;
        req.release_addr = rand_addr();
        req.has_restart  = 1'($urandom_range(1));
        return req;
    endfunction

    function automatic slot_request_t detach_request(input addr_t vaddr);
        slot_request_t req;
        req.command      = CMD_DETACH;
        req.phys_addr    = rand_addr();
        req.release_addr = vaddr;
        req.has_restart  = 1'($urandom_range(1));
        return req;
    endfunction

    function automatic addr_t slot_vaddr(input int idx, input addr_t offs);
        return window_base + (addr_t'(idx) << PAGE_SHIFT) + (offs & PAGE_OFFS);
    endfunction

    function automatic int pick_used_slot();
        int start;
        start = $urandom_range(SLOT_COUNT - 1);
        for (int i = 0; i < SLOT_COUNT; i++)
            if (used_bits[(start + i) % SLOT_COUNT])
                return (start + i) % SLOT_COUNT;
        return -1;
    endfunction

    function automatic addr_t pick_phys();
        int pick;
        pick = $urandom_range(99);
        if (pick < 5)
            return NO_TARGET;
        if (pick < 10)
            return '0;
        return rand_addr();
    endfunction

    task automatic test_directed();
        slot_request_t req;
        req = '{CMD_ATTACH, '0, NO_TARGET, 1'b0};
        send_request(req, pick_gap());
        req = '{CMD_ATTACH_COPY, NO_TARGET, '0, 1'b1};
        send_request(req, pick_gap());
        req = '{CMD_ATTACH, 64'h8000_0000_0000_0000, rand_addr(), 1'b0};
        send_request(req, pick_gap());
        req = '{CMD_ATTACH_COPY, 64'hFFFF_FFFF_FFFF_FFFE, rand_addr(), 1'b1};
        send_request(req, pick_gap());
        // all-ones target reads as empty: no copy-back on this detach
        req = '{CMD_DETACH, rand_addr(), slot_vaddr(1, PAGE_OFFS), 1'b0};
        send_request(req, pick_gap());
        req = '{CMD_ATTACH, 64'h0000_0000_0000_1000, rand_addr(), 1'b0};
        send_request(req, pick_gap());
        req = '{CMD_DETACH, NO_TARGET, slot_vaddr(0, '0), 1'b1};
        send_request(req, pick_gap());
        // slot just released: detach must be rejected
        req = '{CMD_DETACH, '0, slot_vaddr(0, 64'h7FF), 1'b0};
        send_request(req, pick_gap());
        req = '{CMD_DETACH, rand_addr(), slot_vaddr(SLOT_COUNT, '0), 1'b0};
        send_request(req, pick_gap());
        req = '{CMD_DETACH, rand_addr(), NO_TARGET, 1'b1};
        send_request(req, pick_gap());
        req = '{CMD_DETACH, rand_addr(), window_base - 64'd1, 1'b0};
        send_request(req, pick_gap());
        req = '{CMD_INVALID, rand_addr(), slot_vaddr(2, '0), 1'b1};
        send_request(req, pick_gap());
        req = '{CMD_INVALID, NO_TARGET, NO_TARGET, 1'b0};
        send_request(req, pick_gap());
        req = '{CMD_DETACH, rand_addr(), slot_vaddr(2, '0), 1'b0};
        send_request(req, pick_gap());
        req = '{CMD_DETACH, rand_addr(), slot_vaddr(3, 64'h123), 1'b1};
        send_request(req, pick_gap());
        req = '{CMD_DETACH, rand_addr(), slot_vaddr(1, '0), 1'b0};
        send_request(req, pick_gap());
    endtask

    task automatic test_full_window();
        slot_request_t req;
        while (used_bits != SLOT_MASK)
            send_request(attach_request(pick_phys()), pick_gap());
        // window full: both restart flavors, then release and refill
        req = '{CMD_ATTACH, rand_addr(), rand_addr(), 1'b0};
        send_request(req, pick_gap());
        req = '{CMD_ATTACH_COPY, rand_addr(), rand_addr(), 1'b1};
        send_request(req, pick_gap());
        send_request(detach_request(slot_vaddr(pick_used_slot(), rand_addr())), pick_gap());
        send_request(attach_request(pick_phys()), pick_gap());
        send_request(attach_request(pick_phys()), pick_gap());
        send_request(detach_request(slot_vaddr(pick_used_slot(), rand_addr())), pick_gap());
        send_request(detach_request(slot_vaddr(pick_used_slot(), rand_addr())), pick_gap());
        send_request(detach_request(slot_vaddr(SLOT_COUNT - 1, rand_addr())), pick_gap());
        repeat (30)
            send_request(detach_request(slot_vaddr(pick_used_slot(), rand_addr())),
                         pick_gap());
    endtask

    task automatic test_random_mix(input int count);
        slot_request_t req;
        int            pick;
        int            idx;
        for (int n = 0; n < count; n++) begin
            if (n % 40 == 0)
                quiet_mode = ($urandom_range(3) == 0);
            if (n == count / 2)
                wait_for_results();
            pick = $urandom_range(99);
            idx = pick_used_slot();
            if (pick < 45 || (pick < 85 && idx < 0)) begin
                req = attach_request(pick_phys());
            end else if (pick < 85) begin
                req = detach_request(slot_vaddr(idx, rand_addr()));
            end else if (pick < 90) begin
                req = detach_request(slot_vaddr($urandom_range(SLOT_COUNT + 40),
                                                rand_addr()));
            end else if (pick < 95) begin
                req = detach_request(rand_addr());
            end else begin
                req = '{CMD_INVALID, rand_addr(), rand_addr(), 1'($urandom_range(1))};
            end
            send_request(req, pick_gap());
        end
        quiet_mode = 1'b0;
    endtask

    initial begin
        window_base  = '0;
        used_bits    = '0;
        waiters_flag = 1'b0;
        foreach (slot_target[i])
            slot_target[i] = NO_TARGET;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_directed();
        test_full_window();
        write_window_base(TOP_BASE);
        test_random_mix(170);
        write_window_base(rand_addr() & ~PAGE_OFFS);
        test_random_mix(170);
        test_full_window();
        write_window_base('0);
        test_random_mix(150);
        wait_for_results();

        $display("sent %0d requests, checked %0d results, %0d mismatches",
                 requests_sent, outcomes_seen, error_count);
        $display("full-window rejects %0d, copy-backs %0d, wakes %0d, bad detaches %0d",
                 full_hits, copy_backs, wakes, bad_detaches);
        if (error_count == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
